@@ src/frc_pkg.sv @@
// Package with the shared constants of the fragment reassembly checker.
package frc_pkg;

    // Header layout: five big-endian 32-bit words.
    localparam logic [4:0] HDR_BYTES       = 5'd20;
    localparam logic [4:0] MAGIC_LAST_BYTE = 5'd4;
    localparam logic [4:0] SEQ_LAST_BYTE   = 5'd8;
    localparam logic [4:0] ID_LAST_BYTE    = 5'd12;
    localparam logic [4:0] OFF_LAST_BYTE   = 5'd16;

    // Datagram parsing modes.
    localparam logic [1:0] MODE_HEADER  = 2'd0;
    localparam logic [1:0] MODE_PAYLOAD = 2'd1;
    localparam logic [1:0] MODE_DISCARD = 2'd2;

    // Status codes reported at the end of a datagram.
    localparam logic [2:0] STAT_ACCEPTED = 3'd0;
    localparam logic [2:0] STAT_COMPLETE = 3'd1;
    localparam logic [2:0] STAT_DROPPED  = 3'd2;
    localparam logic [2:0] STAT_BAD_MAGIC = 3'd3;
    localparam logic [2:0] STAT_ORPHAN   = 3'd4;
    localparam logic [2:0] STAT_SHORT    = 3'd5;

    // Bit of the pending status word that marks a discarded partial frame.
    localparam int PARTIAL_BIT = 3;

    // Default sizing.
    localparam int DEF_MAX_FRAME_BYTES    = 16777216;
    localparam int DEF_MAX_DATAGRAM_BYTES = 65535;

endpackage

@@ src/fragment_reassembly_checker.sv @@
// Fragment reassembly checker: header parsing, frame tracking and result register.
// Latency: a result appears on the m_ side in the cycle after the byte's input transfer.
// Throughput: one byte per cycle unless the result side stalls; the per-byte state update is a single registered pass.
// A new byte is taken whenever the result register is empty or is being drained.
// Reset (aresetn low at a rising edge) empties the result register, clears the
// frame and parsing state except the header words and sets the expected magic word to zero.
module fragment_reassembly_checker
    import frc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES    = DEF_MAX_FRAME_BYTES,
    parameter int MAX_DATAGRAM_BYTES = DEF_MAX_DATAGRAM_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel: the expected header magic word.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,

    // Received bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,   // last_byte

    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [7:0] data_out, [31:8] position, [34:32] status,
                                   // [35] partial_dropped, [60:36] frame_length,
                                   // [92:61] frame_sequence, [95:93] zero
    output logic        m_tuser,   // [0] has_data
    output logic        m_tlast    // end_of_datagram
);

    // The gathered length must be able to hold the frame limit itself, since
    // the overflow check fires on a byte that arrives with the limit reached.
    localparam int GW  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int PCW = $clog2(MAX_DATAGRAM_BYTES - int'(HDR_BYTES) + 1);
    localparam logic [GW-1:0]  FRAME_LIMIT = GW'(MAX_FRAME_BYTES);
    localparam logic [PCW-1:0] PC_LIMIT    = PCW'(MAX_DATAGRAM_BYTES - int'(HDR_BYTES));

    // Configuration register. The user must keep the block idle during writes, which
    // the block itself does not enforce; the write is always taken at once.
    logic [31:0] magic_reg;

    // Parsing and frame state.
    logic [4:0]     header_count_reg, header_count_next;
    logic [31:0]    word_shift_reg, word_shift_next;
    logic [31:0]    hdr_fields_reg [4];
    logic [31:0]    hdr_fields_next [4];
    logic [1:0]     mode_reg, mode_next;
    logic           frame_open_reg, frame_open_next;
    logic [31:0]    latched_seq_reg, latched_seq_next;
    logic [31:0]    prev_id_reg, prev_id_next;
    logic [31:0]    expected_size_reg, expected_size_next;
    logic [GW-1:0]  gathered_reg, gathered_next;
    logic [PCW-1:0] payload_count_reg, payload_count_next;
    logic           order_bad_reg, order_bad_next;

    // Result of the current byte, before the output register.
    logic           res_valid;
    logic           res_has;
    logic [7:0]     res_data;
    logic [23:0]    res_pos;
    logic [2:0]     res_status;
    logic           res_partial;

    // Output register.
    logic           out_valid_reg;
    logic [95:0]    out_data_reg;
    logic           out_user_reg;
    logic           out_last_reg;

    logic in_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // One pass over the byte: the parsing steps follow each other in order,
    // each seeing what the step before it left.
    always_comb begin
        logic [31:0]   sn;
        logic [31:0]   id;
        logic [31:0]   off;
        logic [31:0]   size;
        logic          hdr_partial;
        logic          start;
        logic [GW-1:0] pos;

        header_count_next  = header_count_reg;
        word_shift_next    = word_shift_reg;
        hdr_fields_next    = hdr_fields_reg;
        mode_next          = mode_reg;
        frame_open_next    = frame_open_reg;
        latched_seq_next   = latched_seq_reg;
        prev_id_next       = prev_id_reg;
        expected_size_next = expected_size_reg;
        gathered_next      = gathered_reg;
        payload_count_next = payload_count_reg;
        order_bad_next     = order_bad_reg;

        sn          = '0;
        id          = '0;
        off         = '0;
        size        = '0;
        hdr_partial = 1'b0;
        start       = 1'b0;
        pos         = '0;
        res_has     = 1'b0;
        res_status  = STAT_ACCEPTED;
        res_partial = 1'b0;

        // A first mark always restarts parsing, even in mid datagram.
        if (s_tuser) begin
            header_count_next  = '0;
            word_shift_next    = '0;
            mode_next          = MODE_HEADER;
            payload_count_next = '0;
        end

        case (mode_next)
            MODE_HEADER: begin
                word_shift_next   = {word_shift_next[23:0], s_tdata};
                header_count_next = header_count_next + 5'd1;
                if (header_count_next == MAGIC_LAST_BYTE && word_shift_next != magic_reg) begin
                    mode_next       = MODE_DISCARD;
                    word_shift_next = 32'(STAT_BAD_MAGIC);
                end else begin
                    case (header_count_next)
                        SEQ_LAST_BYTE: hdr_fields_next[0] = word_shift_next;
                        ID_LAST_BYTE:  hdr_fields_next[1] = word_shift_next;
                        OFF_LAST_BYTE: hdr_fields_next[2] = word_shift_next;
                        HDR_BYTES: begin
                            hdr_fields_next[3] = word_shift_next;
                            sn    = hdr_fields_next[0];
                            id    = hdr_fields_next[1];
                            off   = hdr_fields_next[2];
                            size  = hdr_fields_next[3];
                            start = (id == '0);
                            // A new first fragment discards an open frame.
                            if (id == '0 && frame_open_next) begin
                                frame_open_next = 1'b0;
                                gathered_next   = '0;
                                order_bad_next  = 1'b0;
                                hdr_partial     = 1'b1;
                            end
                            if (id != '0 && !frame_open_next) begin
                                // Continuation with nothing to continue.
                                mode_next       = MODE_DISCARD;
                                word_shift_next = 32'(STAT_ORPHAN);
                            end else begin
                                if (off == '0) begin
                                    latched_seq_next = sn;
                                end
                                // A foreign sequence restarts the frame here.
                                if (sn != latched_seq_next) begin
                                    if (frame_open_next) begin
                                        frame_open_next = 1'b0;
                                        gathered_next   = '0;
                                        order_bad_next  = 1'b0;
                                        hdr_partial     = 1'b1;
                                    end
                                    start = 1'b1;
                                end
                                if (start) begin
                                    frame_open_next    = 1'b1;
                                    gathered_next      = '0;
                                    expected_size_next = size;
                                    prev_id_next       = id;
                                    order_bad_next     = 1'b0;
                                end else begin
                                    if (id != prev_id_next + 32'd1) begin
                                        order_bad_next = 1'b1;
                                    end
                                    prev_id_next = id;
                                end
                                mode_next       = MODE_PAYLOAD;
                                word_shift_next = '0;
                                word_shift_next[PARTIAL_BIT] = hdr_partial;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            MODE_PAYLOAD: begin
                if (payload_count_next >= PC_LIMIT || gathered_next >= FRAME_LIMIT) begin
                    // Overlong datagram or frame overflow: drop and discard the rest.
                    frame_open_next = 1'b0;
                    gathered_next   = '0;
                    order_bad_next  = 1'b0;
                    mode_next       = MODE_DISCARD;
                    word_shift_next = {28'd0, word_shift_next[PARTIAL_BIT], STAT_DROPPED};
                end else begin
                    res_has            = 1'b1;
                    pos                = gathered_next;
                    gathered_next      = gathered_next + GW'(1);
                    payload_count_next = payload_count_next + PCW'(1);
                end
            end
            default: ;
        endcase

        if (s_tlast) begin
            case (mode_next)
                MODE_HEADER: res_status = STAT_SHORT;
                MODE_PAYLOAD: begin
                    res_partial = word_shift_next[PARTIAL_BIT];
                    // The last fragment is the one whose payload reaches the size.
                    if ({1'b0, hdr_fields_next[2]} + 33'(payload_count_next)
                            == {1'b0, hdr_fields_next[3]}) begin
                        if (!order_bad_next && 32'(gathered_next) == expected_size_next) begin
                            res_status      = STAT_COMPLETE;
                            frame_open_next = 1'b0;
                            order_bad_next  = 1'b0;
                        end else begin
                            res_status      = STAT_DROPPED;
                            frame_open_next = 1'b0;
                            gathered_next   = '0;
                            order_bad_next  = 1'b0;
                        end
                    end
                end
                default: begin
                    res_status  = word_shift_next[2:0];
                    res_partial = word_shift_next[PARTIAL_BIT];
                end
            endcase
            header_count_next  = '0;
            word_shift_next    = '0;
            mode_next          = MODE_HEADER;
            payload_count_next = '0;
        end

        res_valid = res_has || s_tlast;
        res_data  = res_has ? s_tdata : 8'd0;
        res_pos   = res_has ? 24'(pos) : 24'd0;
    end

    // Parsing and frame state advances only on an input transfer; the magic word on a configuration write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg         <= '0;
            header_count_reg  <= '0;
            word_shift_reg    <= '0;
            mode_reg          <= MODE_HEADER;
            frame_open_reg    <= 1'b0;
            latched_seq_reg   <= '0;
            prev_id_reg       <= '0;
            expected_size_reg <= '0;
            gathered_reg      <= '0;
            payload_count_reg <= '0;
            order_bad_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                magic_reg <= cfg_data;
            end
            if (in_fire) begin
                header_count_reg  <= header_count_next;
                word_shift_reg    <= word_shift_next;
                mode_reg          <= mode_next;
                frame_open_reg    <= frame_open_next;
                latched_seq_reg   <= latched_seq_next;
                prev_id_reg       <= prev_id_next;
                expected_size_reg <= expected_size_next;
                gathered_reg      <= gathered_next;
                payload_count_reg <= payload_count_next;
                order_bad_reg     <= order_bad_next;
            end
        end
    end

    // Header words are always rewritten before they are read again.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            hdr_fields_reg <= hdr_fields_next;
        end
    end

    // Result register: filled by a byte that has a result, emptied by a
    // transfer on the m_ side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && res_valid) begin
            out_data_reg <= {3'd0, latched_seq_next, 25'(gathered_next), res_partial,
                             res_status, res_pos, res_data};
            out_user_reg <= res_has;
            out_last_reg <= s_tlast;
        end
    end

    // Every result carries a payload byte or closes a datagram.
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser || m_tlast))
        else $error("result with neither payload nor end of datagram");

    // Header parsing always leaves header mode by the end of the header.
    a_header_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_HEADER) |-> (header_count_reg < HDR_BYTES))
        else $error("header count ran past the header in header mode");

    // Counters never pass their limits.
    a_gather_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (gathered_reg <= FRAME_LIMIT) && (payload_count_reg <= PC_LIMIT))
        else $error("frame or datagram counter beyond its limit");

    // A payload byte is only taken while a frame is open; the last byte may close it.
    a_payload_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && res_has) |-> frame_open_reg)
        else $error("payload byte emitted with no open frame");

    // A stalled result is not overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> ($stable(out_data_reg) && out_valid_reg))
        else $error("pending result lost");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the fragment reassembly checker with its own reassembly predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import frc_pkg::*;

    localparam int MAX_FRAME      = DEF_MAX_FRAME_BYTES;
    localparam int MAX_DGRAM      = DEF_MAX_DATAGRAM_BYTES;
    localparam int SETTLE_CYCLES  = 4;
    localparam int BYTES_PER_PASS = 18;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } rx_byte_t;

    typedef struct packed {
        logic        has_data;
        logic [7:0]  data;
        logic [23:0] position;
        logic        eod;
        logic [2:0]  status;
        logic        partial;
        logic [24:0] frame_len;
        logic [31:0] frame_seq;
    } frag_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    fragment_reassembly_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    rx_byte_t     datagram_bytes[$];
    frag_result_t reassembly_results[$];
    int           bytes_queued = 0;
    int           errors = 0;
    bit           quiet = 1'b0;
    int           send_gap = 0;
    int           sink_hold = 0;

    // Predictor state: the copy of the magic register and the parser and frame trackers.
    logic [31:0] magic_word    = '0;
    logic [4:0]  hdr_cnt       = '0;
    logic [31:0] hdr_word      = '0;
    logic [31:0] f_seq         = '0;
    logic [31:0] f_id          = '0;
    logic [31:0] f_off         = '0;
    logic [31:0] f_size        = '0;
    logic [1:0]  parse_mode    = MODE_HEADER;
    logic [2:0]  pend_code     = STAT_ACCEPTED;
    logic        pend_partial  = 1'b0;
    logic        frame_open    = 1'b0;
    logic        order_bad     = 1'b0;
    logic [31:0] latched_seq   = '0;
    logic [31:0] prev_id       = '0;
    logic [31:0] exp_size      = '0;
    logic [24:0] gathered      = '0;
    logic [16:0] dgram_payload = '0;

    function automatic void discard_frame();
        frame_open = 1'b0;
        gathered   = '0;
        order_bad  = 1'b0;
    endfunction

    // Advances the predictor by one received byte; returns 1 when the byte yields a result.
    function automatic bit reassemble_byte(input rx_byte_t b, output frag_result_t res);
        bit          has;
        bit          partial;
        bit          hp;
        bit          start;
        logic [23:0] pos;
        logic [2:0]  status;
        has     = 1'b0;
        partial = 1'b0;
        pos     = '0;
        status  = STAT_ACCEPTED;
        res     = '0;

        // A first mark abandons whatever datagram was in progress.
        if (b.first) begin
            hdr_cnt       = '0;
            hdr_word      = '0;
            pend_code     = STAT_ACCEPTED;
            pend_partial  = 1'b0;
            parse_mode    = MODE_HEADER;
            dgram_payload = '0;
        end

        case (parse_mode)
            MODE_HEADER: begin
                hdr_word = {hdr_word[23:0], b.data};
                hdr_cnt++;
                if (hdr_cnt == MAGIC_LAST_BYTE && hdr_word != magic_word) begin
                    parse_mode = MODE_DISCARD;
                    pend_code  = STAT_BAD_MAGIC;
                end else if (hdr_cnt == SEQ_LAST_BYTE) begin
                    f_seq = hdr_word;
                end else if (hdr_cnt == ID_LAST_BYTE) begin
                    f_id = hdr_word;
                end else if (hdr_cnt == OFF_LAST_BYTE) begin
                    f_off = hdr_word;
                end else if (hdr_cnt == HDR_BYTES) begin
                    f_size = hdr_word;
                    hp     = 1'b0;
                    start  = (f_id == 0);
                    if (f_id == 0 && frame_open) begin
                        discard_frame();
                        hp = 1'b1;
                    end
                    if (f_id != 0 && !frame_open) begin
                        // Continuation with nothing to continue.
                        parse_mode   = MODE_DISCARD;
                        pend_code    = STAT_ORPHAN;
                        pend_partial = 1'b0;
                    end else begin
                        if (f_off == 0)
                            latched_seq = f_seq;
                        // A foreign sequence restarts the frame but is not latched.
                        if (f_seq != latched_seq) begin
                            if (frame_open) begin
                                discard_frame();
                                hp = 1'b1;
                            end
                            start = 1'b1;
                        end
                        if (start) begin
                            frame_open = 1'b1;
                            gathered   = '0;
                            exp_size   = f_size;
                            prev_id    = f_id;
                            order_bad  = 1'b0;
                        end else begin
                            if (f_id != prev_id + 32'd1)
                                order_bad = 1'b1;
                            prev_id = f_id;
                        end
                        parse_mode   = MODE_PAYLOAD;
                        pend_code    = STAT_ACCEPTED;
                        pend_partial = hp;
                    end
                end
            end
            MODE_PAYLOAD: begin
                if (int'(dgram_payload) + int'(HDR_BYTES) >= MAX_DGRAM ||
                    int'(gathered) >= MAX_FRAME) begin
                    discard_frame();
                    parse_mode = MODE_DISCARD;
                    pend_code  = STAT_DROPPED;
                end else begin
                    has = 1'b1;
                    pos = gathered[23:0];
                    gathered++;
                    dgram_payload++;
                end
            end
            default: ;
        endcase

        if (b.last) begin
            if (parse_mode == MODE_HEADER) begin
                status = STAT_SHORT;
            end else if (parse_mode == MODE_PAYLOAD) begin
                partial = pend_partial;
                // The fragment that reaches the announced size closes the frame.
                if (64'(f_off) + 64'(dgram_payload) == 64'(f_size)) begin
                    if (!order_bad && 32'(gathered) == exp_size) begin
                        status     = STAT_COMPLETE;
                        frame_open = 1'b0;
                        order_bad  = 1'b0;
                    end else begin
                        status = STAT_DROPPED;
                        discard_frame();
                    end
                end
            end else begin
                status  = pend_code;
                partial = pend_partial;
            end
            hdr_cnt       = '0;
            hdr_word      = '0;
            pend_code     = STAT_ACCEPTED;
            pend_partial  = 1'b0;
            parse_mode    = MODE_HEADER;
            dgram_payload = '0;
        end

        res.has_data  = has;
        res.data      = has ? b.data : 8'h00;
        res.position  = pos;
        res.eod       = b.last;
        res.status    = status;
        res.partial   = partial;
        res.frame_len = gathered;
        res.frame_seq = latched_seq;
        return has || b.last;
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 15);
        if (r < 9)
            return 0;
        if (r < 15)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Byte driver: takes the next queued byte once the current transfer has completed.
    always @(posedge aclk) begin : byte_driver
        frag_result_t res;
        rx_byte_t     nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (reassemble_byte('{data: s_tdata, first: s_tuser, last: s_tlast}, res))
                    reassembly_results.insert(reassembly_results.size(), res);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0 || datagram_bytes.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (send_gap != 0)
                        send_gap <= send_gap - 1;
                end else begin
                    nxt      = datagram_bytes.pop_front();
                    s_tdata  <= nxt.data;
                    s_tuser  <= nxt.first;
                    s_tlast  <= nxt.last;
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end
            end
        end
    end

    // Result side back-pressure.
    always @(posedge aclk) begin : result_sink
        int next_hold;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold != 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            next_hold = pick_gap();
            sink_hold <= next_hold;
            m_tready  <= (next_hold == 0);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // Every result transfer is matched against the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        frag_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (reassembly_results.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none actual %h/%b/%b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = reassembly_results.pop_front();
                check_field("has_data", 32'(want.has_data), 32'(m_tuser));
                check_field("data_out", 32'(want.data), 32'(m_tdata[7:0]));
                check_field("position", 32'(want.position), 32'(m_tdata[31:8]));
                check_field("end_of_datagram", 32'(want.eod), 32'(m_tlast));
                check_field("status", 32'(want.status), 32'(m_tdata[34:32]));
                check_field("partial_dropped", 32'(want.partial), 32'(m_tdata[35]));
                check_field("frame_length", 32'(want.frame_len), 32'(m_tdata[60:36]));
                check_field("frame_sequence", want.frame_seq, m_tdata[92:61]);
                check_field("tdata padding", 32'd0, 32'(m_tdata[95:93]));
            end
        end
    end

    task automatic push_rx(input logic [7:0] d, input bit f, input bit l);
        rx_byte_t item;
        item = '{data: d, first: f, last: l};
        datagram_bytes.insert(datagram_bytes.size(), item);
        bytes_queued++;
    endtask

    // Queues one datagram: big-endian header, random payload. A nonzero cut sets its length.
    task automatic queue_datagram(input logic [31:0] magic, seq, id, off, size,
                                  input int payload_len, input int cut = 0,
                                  input bit mark_first = 1'b1, input bit mark_last = 1'b1);
        logic [31:0] words[5];
        logic [7:0]  d;
        int          total;
        words = '{magic, seq, id, off, size};
        total = (cut > 0) ? cut : int'(HDR_BYTES) + payload_len;
        for (int i = 0; i < total; i++) begin
            if (i < int'(HDR_BYTES))
                d = 8'(words[i / 4] >> (8 * (3 - i % 4)));
            else
                d = 8'($urandom_range(0, 255));
            push_rx(d, mark_first && i == 0, mark_last && i == total - 1);
        end
    endtask

    // One frame split into fragments, mostly well formed, with occasional damage.
    task automatic queue_random_frame();
        logic [31:0] seq;
        logic [31:0] id;
        logic [31:0] size;
        logic [31:0] magic;
        logic [31:0] seq_f;
        logic [31:0] off_f;
        int          lens[4];
        int          nfrag;
        int          total;
        int          off;
        int          cut;
        seq   = $urandom;
        nfrag = $urandom_range(1, 4);
        total = 0;
        for (int i = 0; i < nfrag; i++) begin
            lens[i] = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120)
                                                    : $urandom_range(0, 8);
            total += lens[i];
        end
        off = 0;
        for (int i = 0; i < nfrag; i++) begin
            id = i;
            if ($urandom_range(0, 11) == 0)
                id = ($urandom_range(0, 1) == 0) ? id + $urandom_range(1, 3) : $urandom;
            size = total;
            if ($urandom_range(0, 11) == 0)
                size = total + $urandom_range(1, 2);
            magic = magic_word;
            if ($urandom_range(0, 15) == 0)
                magic = magic ^ (32'd1 << $urandom_range(0, 31));
            seq_f = ($urandom_range(0, 11) == 0) ? $urandom : seq;
            off_f = ($urandom_range(0, 19) == 0) ? $urandom : off;
            cut   = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 19) : 0;
            queue_datagram(magic, seq_f, id, off_f, size, lens[i], cut,
                           $urandom_range(0, 15) != 0, $urandom_range(0, 19) != 0);
            off += lens[i];
        end
        // Stray bytes with random marks between frames.
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 6))
                push_rx(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        end
    endtask

    // Waits until every byte is taken and every predicted result has arrived.
    task automatic settle();
        while (datagram_bytes.size() != 0 || s_tvalid || reassembly_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_magic(input logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        magic_word = value;
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int target;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Magic still at its reset value of zero.
        queue_datagram(32'h0, 32'h0, 32'h0, 32'h0, 32'd2, 2);
        settle();
        write_magic(32'hA5C3_0F96);

        // Short datagrams and bad magic; bad magic wins once its fourth byte is in.
        push_rx(8'hFF, 1'b1, 1'b1);
        queue_datagram(~magic_word, 32'h1, 32'h0, 32'h0, 32'd1, 0, 3);
        queue_datagram(~magic_word, 32'h1, 32'h0, 32'h0, 32'd1, 0, 6);
        queue_datagram(32'h0, 32'h1, 32'h0, 32'h0, 32'd4, 4);
        queue_datagram(magic_word, 32'h1, 32'h0, 32'h0, 32'd4, 4, 13);
        // A continuation with no open frame.
        queue_datagram(magic_word, 32'h2, 32'd5, 32'd4, 32'd8, 4);
        // Two in-order fragments that complete.
        queue_datagram(magic_word, 32'h1111_0001, 32'd0, 32'd0, 32'd5, 2);
        queue_datagram(magic_word, 32'h1111_0001, 32'd1, 32'd2, 32'd5, 3);
        // Skipped fragment id.
        queue_datagram(magic_word, 32'h2222_0002, 32'd0, 32'd0, 32'd4, 2);
        queue_datagram(magic_word, 32'h2222_0002, 32'd3, 32'd2, 32'd4, 2);
        // Final fragment reached with too few bytes gathered.
        queue_datagram(magic_word, 32'h3333_0003, 32'd0, 32'd0, 32'd6, 2);
        queue_datagram(magic_word, 32'h3333_0003, 32'd1, 32'd4, 32'd6, 2);
        // A new id 0 discards the open frame.
        queue_datagram(magic_word, 32'h4444_0004, 32'd0, 32'd0, 32'd10, 3);
        queue_datagram(magic_word, 32'h4444_0004, 32'd0, 32'd0, 32'd3, 3);
        // A sequence change restarts the frame without relatching, twice.
        queue_datagram(magic_word, 32'h5555_0005, 32'd0, 32'd0, 32'd10, 2);
        queue_datagram(magic_word, 32'h6666_0006, 32'd1, 32'd2, 32'd10, 2);
        queue_datagram(magic_word, 32'h6666_0006, 32'd2, 32'd4, 32'd10, 6);
        // Header-only datagram that opens and completes an empty frame.
        queue_datagram(magic_word, 32'h0000_0000, 32'd0, 32'd0, 32'd0, 0);
        // A first mark in mid datagram, then the continuation completes the frame.
        queue_datagram(magic_word, 32'h7777_0007, 32'd0, 32'd0, 32'd8, 8, 25, 1'b1, 1'b0);
        queue_datagram(magic_word, 32'h7777_0007, 32'd1, 32'd5, 32'd8, 3);
        // No first mark after a last byte.
        queue_datagram(magic_word, 32'h8888_0008, 32'd0, 32'd0, 32'd3, 3, 0, 1'b0);
        // Field extremes: all-ones id, offset and size, then all-ones sequence.
        queue_datagram(magic_word, 32'h9999_0009, 32'd0, 32'd0, 32'hFFFF_FFFF, 1);
        queue_datagram(magic_word, 32'h9999_0009, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1);
        queue_datagram(magic_word, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1, 1);

        // Random frames under three magic settings; the middle pass runs without idling.
        for (int p = 0; p < 3; p++) begin
            settle();
            write_magic(p == 0 ? 32'hFFFF_FFFF : p == 1 ? 32'h0000_0000 : 32'($urandom));
            quiet  = (p == 1);
            target = bytes_queued + BYTES_PER_PASS;
            while (bytes_queued < target)
                queue_random_frame();
        end
        settle();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
src/frc_pkg.sv
src/fragment_reassembly_checker.sv
test/testbench.sv
